// ===== hw/rtl/calt_pkg.sv =====
package calt_pkg;

	localparam int unsigned CHAN_W = 8;
	localparam int unsigned LEN_W  = 8;

	typedef logic [CHAN_W-1:0] chan_t;
	typedef logic [LEN_W-1:0]  len_t;

	typedef struct packed {
		chan_t r;
		chan_t g;
		chan_t b;
	} color_t;

	localparam logic [1:0] REG_ARM_LIMIT       = 2'd0;
	localparam logic [1:0] REG_LONG_ARM_START  = 2'd1;
	localparam logic [1:0] REG_COLOR_THRESHOLD = 2'd2;
	localparam logic [1:0] REG_TIGHT_THRESHOLD = 2'd3;

	localparam len_t ARM_LIMIT_RST       = 8'd34;
	localparam len_t LONG_ARM_START_RST  = 8'd17;
	localparam chan_t COLOR_THRESHOLD_RST = 8'd20;
	localparam chan_t TIGHT_THRESHOLD_RST = 8'd6;

endpackage

// ===== hw/rtl/calt_color_dist.sv =====
module calt_color_dist
	import calt_pkg::*;
(
	input  color_t a,
	input  color_t b,
	output chan_t  max_gap
);

	chan_t gap_r;
	chan_t gap_g;
	chan_t gap_b;
	chan_t max_rg;

	assign gap_r   = (a.r > b.r) ? a.r - b.r : b.r - a.r;
	assign gap_g   = (a.g > b.g) ? a.g - b.g : b.g - a.g;
	assign gap_b   = (a.b > b.b) ? a.b - b.b : b.b - a.b;
	assign max_rg  = (gap_g > gap_r) ? gap_g : gap_r;
	assign max_gap = (gap_b > max_rg) ? gap_b : max_rg;

endmodule

// ===== hw/rtl/cross_arm_length_tracker_unit.sv =====
// Cross-arm length tracker for adaptive support aggregation.
// Input channel (in_valid/in_stall) carries one pixel per transfer. A pixel
// with is_center set opens a new arm; the following pixels walk outward.
// Output channel (out_valid/out_stall) carries one arm_length per ended arm.
// An arm ends on a color break against the center or the previous pixel,
// on the tight threshold past long_arm_start, at the length limit, or at
// a border pixel. Pixels that arrive while no arm is open are dropped.
// Each pixel is held in an input register, evaluated combinationally
// against the stored center and previous colors, and the result lands
// in an output register that drives out_valid and arm_length. One pixel
// is accepted every cycle while in_stall is low.
// When out_stall is high the output register holds its result; pixels
// that produce no result keep flowing, and a pixel that would produce a
// result waits in the input register, which then raises in_stall.
// Reset clears all control state, loads the register defaults and leaves
// the tracker waiting for a center. Configuration writes are expected only
// while the tracker is idle.
module cross_arm_length_tracker_unit
	import calt_pkg::*;
#(
	parameter int unsigned MAX_ARM = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       is_center,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	input  logic       at_border,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] arm_length
);

	len_t   arm_limit_q;
	len_t   long_arm_start_q;
	chan_t  color_threshold_q;
	chan_t  tight_threshold_q;

	logic   valid_s1;
	logic   center_s1;
	color_t color_s1;
	logic   border_s1;

	color_t center_color_q;
	color_t prev_color_q;
	len_t   len_q;
	logic   arm_done_q;

	logic   out_valid_q;
	len_t   arm_length_q;

	len_t   limit;
	chan_t  dist_center;
	chan_t  dist_prev;
	logic [LEN_W:0] len_inc;
	logic   reject;
	logic   reach_end;
	logic   res_s1;
	len_t   res_len;
	logic   advance;
	logic   fire_s1;
	logic   in_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_limit_q       <= ARM_LIMIT_RST;
			long_arm_start_q  <= LONG_ARM_START_RST;
			color_threshold_q <= COLOR_THRESHOLD_RST;
			tight_threshold_q <= TIGHT_THRESHOLD_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_ARM_LIMIT:       arm_limit_q       <= cfg_data;
				REG_LONG_ARM_START:  long_arm_start_q  <= cfg_data;
				REG_COLOR_THRESHOLD: color_threshold_q <= cfg_data;
				REG_TIGHT_THRESHOLD: tight_threshold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign limit = (arm_limit_q < len_t'(MAX_ARM)) ? arm_limit_q : len_t'(MAX_ARM);

	calt_color_dist u_dist_center (
		.a       (color_s1),
		.b       (center_color_q),
		.max_gap (dist_center)
	);

	calt_color_dist u_dist_prev (
		.a       (color_s1),
		.b       (prev_color_q),
		.max_gap (dist_prev)
	);

	assign len_inc = {1'b0, len_q} + {{LEN_W{1'b0}}, 1'b1};

	always_comb begin
		reject = (dist_center >= color_threshold_q)
			|| ((len_q != '0) && (dist_prev >= color_threshold_q))
			|| ((len_inc > {1'b0, long_arm_start_q}) && (dist_center >= tight_threshold_q));
		reach_end = (len_inc[LEN_W-1:0] >= limit) || border_s1;
		res_s1  = 1'b0;
		res_len = len_q;
		if (center_s1) begin
			res_s1  = (limit == '0) || border_s1;
			res_len = '0;
		end else if (!arm_done_q) begin
			if (reject) begin
				res_s1  = 1'b1;
				res_len = len_q;
			end else begin
				res_s1  = reach_end;
				res_len = len_inc[LEN_W-1:0];
			end
		end
	end

	assign advance  = !res_s1 || !out_valid_q || !out_stall;
	assign fire_s1  = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign in_fire  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			center_s1 <= is_center;
			color_s1  <= '{r: red, g: green, b: blue};
			border_s1 <= at_border;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_color_q <= '0;
			prev_color_q   <= '0;
			len_q          <= '0;
			arm_done_q     <= 1'b1;
		end else if (fire_s1) begin
			if (center_s1) begin
				center_color_q <= color_s1;
				prev_color_q   <= color_s1;
				len_q          <= '0;
				arm_done_q     <= (limit == '0) || border_s1;
			end else if (!arm_done_q) begin
				if (!reject) begin
					len_q        <= len_inc[LEN_W-1:0];
					prev_color_q <= color_s1;
				end
				if (res_s1) begin
					arm_done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && res_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && res_s1) begin
			arm_length_q <= res_len;
		end
	end

	assign out_valid  = out_valid_q;
	assign arm_length = arm_length_q;

	// A held result is never overwritten by a new one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !(fire_s1 && res_s1))
		else $error("result register overwritten while stalled");

	// Every result closes the arm.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && res_s1) |=> arm_done_q)
		else $error("arm still open after its result");

	// A pixel outside an open arm never yields a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !center_s1 && arm_done_q) |-> !res_s1)
		else $error("result from a pixel outside an arm");

	// The arm grows by at most one pixel per transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && !center_s1) |=>
		((len_q == $past(len_q)) || (len_q == len_t'($past(len_q) + 8'd1))))
		else $error("arm length jumped");

	// A center always restarts the length count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && center_s1) |=> (len_q == '0))
		else $error("length not cleared by center");

endmodule

// ===== tb/arm_length_checker.sv =====
module arm_length_checker
	import calt_pkg::*;
#(
	parameter int unsigned MAX_ARM = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic       is_center,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	input  logic       at_border,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] arm_length,
	output int         pending,
	output int         errors
);

	len_t   limit_q;
	len_t   long_start_q;
	chan_t  color_thr_q;
	chan_t  tight_thr_q;

	color_t anchor_color;
	color_t last_color;
	len_t   run_length;
	logic   arm_closed;

	len_t   length_queue[$];
	len_t   want;

	function automatic chan_t channel_gap(chan_t a, chan_t b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic chan_t max_channel_gap(color_t a, color_t b);
		chan_t gap;
		chan_t tmp;
		gap = channel_gap(a.r, b.r);
		tmp = channel_gap(a.g, b.g);
		if (tmp > gap) gap = tmp;
		tmp = channel_gap(a.b, b.b);
		if (tmp > gap) gap = tmp;
		return gap;
	endfunction

	// Advances the arm by one accepted pixel and queues the length when the arm closes.
	task automatic walk_arm(input logic center, input color_t px, input logic border);
		len_t  cap;
		chan_t to_anchor;
		logic  halt;
		cap = (limit_q < MAX_ARM) ? limit_q : len_t'(MAX_ARM);
		if (center) begin
			anchor_color = px;
			last_color = px;
			run_length = '0;
			arm_closed = (cap == 0) || border;
			if (arm_closed) length_queue.push_back('0);
		end else if (!arm_closed) begin
			to_anchor = max_channel_gap(px, anchor_color);
			halt = (to_anchor >= color_thr_q)
				|| (run_length != 0 && max_channel_gap(px, last_color) >= color_thr_q)
				|| (({1'b0, run_length} + 9'd1) > {1'b0, long_start_q}
					&& to_anchor >= tight_thr_q);
			if (!halt) begin
				run_length = run_length + 1'b1;
				last_color = px;
				halt = (run_length >= cap) || border;
			end
			if (halt) begin
				arm_closed = 1'b1;
				length_queue.push_back(run_length);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q = ARM_LIMIT_RST;
			long_start_q = LONG_ARM_START_RST;
			color_thr_q = COLOR_THRESHOLD_RST;
			tight_thr_q = TIGHT_THRESHOLD_RST;
			anchor_color = '0;
			last_color = '0;
			run_length = '0;
			arm_closed = 1'b1;
			length_queue.delete();
			pending = 0;
			errors = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (length_queue.size() == 0) begin
					$error("arm_length: expected none, actual %0d", arm_length);
					errors++;
				end else begin
					want = length_queue.pop_front();
					if (arm_length !== want) begin
						$error("arm_length: expected %0d, actual %0d", want, arm_length);
						errors++;
					end
				end
			end
			if (cfg_write) begin
				case (cfg_index)
					REG_ARM_LIMIT:       limit_q = cfg_data;
					REG_LONG_ARM_START:  long_start_q = cfg_data;
					REG_COLOR_THRESHOLD: color_thr_q = cfg_data;
					REG_TIGHT_THRESHOLD: tight_thr_q = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				walk_arm(is_center, {red, green, blue}, at_border);
			pending = length_queue.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
module tb;
	import calt_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;

	logic       clk;
	logic       arst_n;
	logic       cfg_write;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;
	logic       in_valid;
	logic       in_stall;
	logic       is_center;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       at_border;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] arm_length;

	int         pending;
	int         errors;
	int         idle_cycles = 0;
	logic       steady = 1'b0;
	len_t       limit_now;

	cross_arm_length_tracker_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.is_center  (is_center),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.at_border  (at_border),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.arm_length (arm_length)
	);

	arm_length_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.is_center  (is_center),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.at_border  (at_border),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.arm_length (arm_length),
		.pending    (pending),
		.errors     (errors)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(negedge clk) begin
		out_stall <= !steady && ($urandom_range(0, 99) < 15);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("cross_arm_length_tracker_unit: mismatch");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic color_t random_color();
		color_t c;
		c = color_t'($urandom);
		if ($urandom_range(0, 3) == 0) c.r = $urandom_range(0, 1) ? 8'hff : 8'h00;
		if ($urandom_range(0, 3) == 0) c.g = $urandom_range(0, 1) ? 8'hff : 8'h00;
		if ($urandom_range(0, 3) == 0) c.b = $urandom_range(0, 1) ? 8'hff : 8'h00;
		return c;
	endfunction

	function automatic chan_t nudge_channel(chan_t c, int spread);
		int v;
		v = int'(c) + int'($urandom_range(0, 2 * spread)) - spread;
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return chan_t'(v);
	endfunction

	task automatic send_pixel(input logic center, input color_t px, input logic border);
		if (!steady && $urandom_range(0, 99) < 10) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(negedge clk);
		end
		in_valid <= 1'b1;
		is_center <= center;
		red <= px.r;
		green <= px.g;
		blue <= px.b;
		at_border <= border;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// Waits until every expected length has come out, then lets the pipeline settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_registers(input len_t lim, input len_t las, input chan_t ct,
			input chan_t tt);
		cfg_write <= 1'b1;
		cfg_index <= REG_ARM_LIMIT;
		cfg_data <= lim;
		@(negedge clk);
		cfg_index <= REG_LONG_ARM_START;
		cfg_data <= las;
		@(negedge clk);
		cfg_index <= REG_COLOR_THRESHOLD;
		cfg_data <= ct;
		@(negedge clk);
		cfg_index <= REG_TIGHT_THRESHOLD;
		cfg_data <= tt;
		@(negedge clk);
		cfg_write <= 1'b0;
		limit_now = lim;
	endtask

	// Mostly well-formed arms drifting from a center, with some stray pixels and centers.
	task automatic run_arms(input int items);
		int     sent;
		int     steps;
		int     spread;
		color_t walk;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(0, 9) == 0) begin
				send_pixel($urandom_range(0, 3) == 0, random_color(),
					$urandom_range(0, 1) == 1);
				sent++;
			end else begin
				walk = random_color();
				send_pixel(1'b1, walk, $urandom_range(0, 19) == 0);
				sent++;
				steps = ($urandom_range(0, 7) == 0) ? int'(limit_now) + 2
					: $urandom_range(0, 24);
				spread = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 8);
				repeat (steps) begin
					walk.r = nudge_channel(walk.r, spread);
					walk.g = nudge_channel(walk.g, spread);
					walk.b = nudge_channel(walk.b, spread);
					send_pixel(1'b0, walk, $urandom_range(0, 29) == 0);
					sent++;
				end
			end
		end
	endtask

	initial begin
		len_t lim;
		len_t las;
		chan_t ct;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_ARM_LIMIT;
		cfg_data = '0;
		in_valid = 1'b0;
		is_center = 1'b0;
		red = '0;
		green = '0;
		blue = '0;
		at_border = 1'b0;
		limit_now = ARM_LIMIT_RST;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_registers(8'd3, 8'd2, 8'd20, 8'd6);
		send_pixel(1'b0, {8'd255, 8'd255, 8'd255}, 1'b1);
		send_pixel(1'b1, {8'd100, 8'd100, 8'd100}, 1'b0);
		send_pixel(1'b0, {8'd105, 8'd100, 8'd100}, 1'b0);
		send_pixel(1'b0, {8'd100, 8'd104, 8'd100}, 1'b0);
		send_pixel(1'b0, {8'd100, 8'd100, 8'd106}, 1'b1);
		send_pixel(1'b0, {8'd0, 8'd0, 8'd0}, 1'b0);
		send_pixel(1'b1, {8'd10, 8'd20, 8'd30}, 1'b0);
		send_pixel(1'b0, {8'd10, 8'd20, 8'd30}, 1'b0);
		send_pixel(1'b0, {8'd12, 8'd20, 8'd30}, 1'b0);
		send_pixel(1'b0, {8'd14, 8'd20, 8'd30}, 1'b0);
		send_pixel(1'b1, {8'd0, 8'd0, 8'd0}, 1'b1);
		send_pixel(1'b1, {8'd0, 8'd0, 8'd0}, 1'b0);
		send_pixel(1'b0, {8'd19, 8'd0, 8'd0}, 1'b0);
		send_pixel(1'b1, {8'd255, 8'd255, 8'd255}, 1'b0);
		send_pixel(1'b0, {8'd255, 8'd255, 8'd255}, 1'b1);
		send_pixel(1'b1, {8'd255, 8'd0, 8'd255}, 1'b0);
		send_pixel(1'b0, {8'd0, 8'd0, 8'd0}, 1'b0);
		send_pixel(1'b1, {8'd128, 8'd128, 8'd128}, 1'b0);
		send_pixel(1'b0, {8'd147, 8'd128, 8'd128}, 1'b0);
		send_pixel(1'b0, {8'd109, 8'd128, 8'd128}, 1'b0);
		drain();

		set_registers(ARM_LIMIT_RST, LONG_ARM_START_RST, COLOR_THRESHOLD_RST,
			TIGHT_THRESHOLD_RST);
		run_arms(300);
		drain();
		set_registers(8'd0, len_t'($urandom), chan_t'($urandom), chan_t'($urandom));
		run_arms(200);
		drain();
		steady = 1'b1;
		set_registers(8'd255, 8'd255, 8'd255, 8'd255);
		run_arms(300);
		drain();
		steady = 1'b0;
		set_registers(8'd40, 8'd10, 8'd0, 8'd0);
		run_arms(150);
		drain();
		set_registers(8'd12, 8'd0, 8'd30, 8'd0);
		run_arms(200);
		drain();
		repeat (3) begin
			lim = len_t'($urandom_range(1, 40));
			las = len_t'($urandom_range(0, lim));
			ct = chan_t'($urandom_range(1, 60));
			set_registers(lim, las, ct, chan_t'($urandom_range(0, ct)));
			run_arms(300);
			drain();
		end

		repeat (8) @(negedge clk);
		if (errors == 0 && pending == 0) begin
			$display("cross_arm_length_tracker_unit: match");
		end else begin
			$display("cross_arm_length_tracker_unit: mismatch");
		end
		$finish;
	end

endmodule
